// ----- rtl/u8u16_pkg.sv -----
package u8u16_pkg;

	// Error kinds reported in the error_kind field.
	typedef enum logic [2:0] {
		ERR_LEAD      = 3'd0,
		ERR_CONT      = 3'd1,
		ERR_OVERLONG  = 3'd2,
		ERR_SURROGATE = 3'd3,
		ERR_RANGE     = 3'd4
	} err_kind_t;

	localparam int unsigned PointW = 21;
	localparam int unsigned UnitW  = 16;

	localparam logic [PointW-1:0] MinPoint2  = 21'h000080;
	localparam logic [PointW-1:0] MinPoint3  = 21'h000800;
	localparam logic [PointW-1:0] MinPoint4  = 21'h010000;
	localparam logic [PointW-1:0] SurrLo     = 21'h00D800;
	localparam logic [PointW-1:0] SurrHi     = 21'h00DFFF;
	localparam logic [PointW-1:0] MaxPoint   = 21'h10FFFF;
	localparam logic [PointW-1:0] BmpMax     = 21'h00FFFF;
	localparam logic [PointW-1:0] SuppBase   = 21'h010000;
	localparam logic [5:0]        HighPrefix = 6'b110110;
	localparam logic [5:0]        LowPrefix  = 6'b110111;

	// One result item.
	typedef struct packed {
		logic [UnitW-1:0] code_unit;
		logic             error_flag;
		err_kind_t        error_kind;
		logic             run_last;
		logic             closes_string;
	} result_t;

	// Sequence length of a lead byte; zero for a byte that cannot lead.
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		priority if (b[7] == 1'b0) len = 3'd1;
		else if (b[7:5] == 3'b110) len = 3'd2;
		else if (b[7:4] == 4'b1110) len = 3'd3;
		else if (b[7:3] == 5'b11110) len = 3'd4;
		else len = 3'd0;
		return len;
	endfunction

endpackage

// ----- rtl/utf8_to_utf16_transcoder.sv -----
// UTF-8 to UTF-16 transcoder.
// The slave channel takes one UTF-8 byte per transfer in s_tdata, with
// s_tlast marking the final byte of a string. The master channel gives
// UTF-16 code units in m_tdata, with m_tuser flagging error items and their
// kind, and m_tlast set on the last result item of a string.
// A byte is held in an input register and decoded against the sequence
// state; its results land in an output register, so a byte passes the input
// register and then the output register before its first result is offered.
// Throughput is one byte per cycle while the receiver takes every item and
// no low surrogate is pending. A code point above the basic plane gives two
// code units; the low surrogate waits in a pending register and the input
// register holds while it is sent. Bytes that complete nothing give no
// result and pass at full rate while the output register is free.
// After an error one error item is sent and the rest of the string is
// dropped, unless the error came on the string's final byte.
// Reset clears the sequence state, the dropping flag and all valid flags;
// the block takes a byte on the first cycle after reset is released.
// When the receiver stalls, the output and pending registers hold their
// items and the input register fills, after which s_tready falls.
module utf8_to_utf16_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // string_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [15:0] code_unit, [16] run_last, [23:17] zero
	output logic [3:0]  m_tuser,  // [0] error_flag, [3:1] error_kind
	output logic        m_tlast   // closes_string
);

	// Input register.
	logic       in_valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Sequence state.
	logic [u8u16_pkg::PointW-1:0] partial_q;
	logic [1:0]                   left_q;
	logic [2:0]                   seqlen_q;
	logic                         bad_q;
	logic                         drop_q;

	// Output register and the pending second unit of a surrogate pair.
	logic                 out_valid_q;
	u8u16_pkg::result_t   out_q;
	logic                 pend_valid_q;
	u8u16_pkg::result_t   pend_q;

	// Decode results.
	logic [u8u16_pkg::PointW-1:0] partial_d;
	logic [1:0]                   left_d;
	logic [2:0]                   seqlen_d;
	logic                         bad_d;
	logic                         drop_d;
	logic [1:0]                   nres;
	u8u16_pkg::result_t           res0;
	u8u16_pkg::result_t           res1;

	logic                         fire;
	logic                         out_free;
	logic [2:0]                   len;
	logic [u8u16_pkg::PointW-1:0] cont_point;
	logic [u8u16_pkg::PointW-1:0] emit_cp;
	logic [u8u16_pkg::PointW-1:0] supp;
	logic [u8u16_pkg::PointW-1:0] min_cp;
	logic [1:0]                   left_dec;
	logic                         do_emit;
	logic                         do_err;
	u8u16_pkg::err_kind_t         kind;

	assign out_free = !out_valid_q || m_tready;
	// The decoded byte moves on once its results have somewhere to go.
	assign fire     = in_valid_s1 && !pend_valid_q && out_free;
	assign s_tready = !in_valid_s1 || fire;

	assign len        = u8u16_pkg::lead_length(byte_s1);
	assign cont_point = {partial_q[u8u16_pkg::PointW-7:0], byte_s1[5:0]};
	assign left_dec   = left_q - 2'd1;
	assign supp       = emit_cp - u8u16_pkg::SuppBase;

	always_comb begin
		unique case (seqlen_q)
			3'd2:    min_cp = u8u16_pkg::MinPoint2;
			3'd3:    min_cp = u8u16_pkg::MinPoint3;
			default: min_cp = u8u16_pkg::MinPoint4;
		endcase
	end

	// Sequence decode for the byte in the input register.
	always_comb begin
		partial_d = partial_q;
		left_d    = left_q;
		seqlen_d  = seqlen_q;
		bad_d     = bad_q;
		drop_d    = drop_q;
		do_emit   = 1'b0;
		do_err    = 1'b0;
		kind      = u8u16_pkg::ERR_LEAD;
		emit_cp   = {{(u8u16_pkg::PointW-8){1'b0}}, byte_s1};

		if (drop_q) begin
			if (end_s1) begin
				drop_d = 1'b0;
			end
		end else if (left_q == 2'd0) begin
			if (len == 3'd0) begin
				do_err = 1'b1;
			end else if (len == 3'd1) begin
				do_emit = 1'b1;
			end else if (end_s1) begin
				do_err = 1'b1;
			end else begin
				unique case (len)
					3'd2:    partial_d = {{(u8u16_pkg::PointW-5){1'b0}}, byte_s1[4:0]};
					3'd3:    partial_d = {{(u8u16_pkg::PointW-4){1'b0}}, byte_s1[3:0]};
					default: partial_d = {{(u8u16_pkg::PointW-3){1'b0}}, byte_s1[2:0]};
				endcase
				left_d   = len[1:0] - 2'd1;
				seqlen_d = len;
				bad_d    = 1'b0;
			end
		end else begin
			partial_d = cont_point;
			left_d    = left_dec;
			bad_d     = bad_q || (byte_s1[7:6] != 2'b10);
			emit_cp   = cont_point;
			if (left_dec != 2'd0) begin
				// A string that ends inside a sequence counts as a bad lead.
				if (end_s1) begin
					do_err = 1'b1;
				end
			end else if (bad_d) begin
				do_err = 1'b1;
				kind   = u8u16_pkg::ERR_CONT;
			end else if (cont_point < min_cp) begin
				do_err = 1'b1;
				kind   = u8u16_pkg::ERR_OVERLONG;
			end else if (cont_point >= u8u16_pkg::SurrLo &&
				cont_point <= u8u16_pkg::SurrHi) begin
				do_err = 1'b1;
				kind   = u8u16_pkg::ERR_SURROGATE;
			end else if (cont_point > u8u16_pkg::MaxPoint) begin
				do_err = 1'b1;
				kind   = u8u16_pkg::ERR_RANGE;
			end else begin
				do_emit = 1'b1;
			end
		end

		// Any result closes the open sequence.
		if (do_err || do_emit || (drop_q && end_s1)) begin
			partial_d = '0;
			left_d    = 2'd0;
			seqlen_d  = 3'd0;
			bad_d     = 1'b0;
		end
		if (do_err) begin
			drop_d = !end_s1;
		end
	end

	// Result items for the decoded byte.
	always_comb begin
		res0 = '{code_unit: '0, error_flag: 1'b0, error_kind: u8u16_pkg::ERR_LEAD,
			run_last: 1'b1, closes_string: end_s1};
		res1 = res0;
		nres = 2'd0;
		if (do_err) begin
			nres               = 2'd1;
			res0.error_flag    = 1'b1;
			res0.error_kind    = kind;
			res0.closes_string = 1'b1;
		end else if (do_emit) begin
			if (emit_cp <= u8u16_pkg::BmpMax) begin
				nres           = 2'd1;
				res0.code_unit = emit_cp[u8u16_pkg::UnitW-1:0];
			end else begin
				nres               = 2'd2;
				res0.code_unit     = {u8u16_pkg::HighPrefix, supp[19:10]};
				res0.run_last      = 1'b0;
				res0.closes_string = 1'b0;
				res1.code_unit     = {u8u16_pkg::LowPrefix, supp[9:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			left_q    <= 2'd0;
			seqlen_q  <= 3'd0;
			bad_q     <= 1'b0;
			drop_q    <= 1'b0;
		end else if (fire) begin
			partial_q <= partial_d;
			left_q    <= left_d;
			seqlen_q  <= seqlen_d;
			bad_q     <= bad_d;
			drop_q    <= drop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= fire && (nres != 2'd0);
				pend_valid_q <= fire && (nres == 2'd2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (fire) begin
				out_q  <= res0;
				pend_q <= res1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.run_last, out_q.code_unit};
	assign m_tuser  = {out_q.error_kind, out_q.error_flag};
	assign m_tlast  = out_q.closes_string;

	// A pending low surrogate always sits behind a valid output item.
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending unit without an output item");

	// The pending item is only ever the low half of a pair.
	a_pend_low_half: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (!pend_q.error_flag &&
			pend_q.code_unit[15:10] == u8u16_pkg::LowPrefix))
		else $error("pending item is not a low surrogate");

	// An error item is final for its byte and for its string.
	a_err_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.error_flag) |-> (out_q.run_last && out_q.closes_string))
		else $error("error item does not close the string");

	// A high surrogate is always followed by its low half.
	a_high_then_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.error_flag &&
			out_q.code_unit[15:10] == u8u16_pkg::HighPrefix) |-> pend_valid_q)
		else $error("high surrogate without pending low half");

	// While dropping, no sequence is open.
	a_drop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (left_q == 2'd0 && !bad_q))
		else $error("sequence open while dropping");

endmodule

// ----- test/utf8_to_utf16_transcoder_tb.sv -----
module utf8_to_utf16_transcoder_tb;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tlast;   // string_end
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [15:0] code_unit, [16] run_last, [23:17] zero
	logic [3:0]  m_tuser;   // [0] error_flag, [3:1] error_kind
	logic        m_tlast;   // closes_string

	localparam int TargetBytes = 1300;
	localparam int QuietFrom   = 1150;  // no idling on either side from here on
	localparam int HoldAt      = 400;   // long receiver hold-off starts here
	localparam int HoldCycles  = 80;
	localparam int DrainAt     = 800;   // sender waits for every result here
	localparam int CycleLimit  = 300000;

	utf8_to_utf16_transcoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Decoder state as the testbench sees it, advanced once per accepted byte.
	logic [20:0] acc_point;
	logic [1:0]  cont_left;
	logic [2:0]  seq_len;
	logic        cont_broken;
	logic        skipping;

	u8u16_pkg::result_t pending_units[$];  // code units and error items still to come
	logic [7:0]  octets[$];         // bytes of the string being sent
	int          sent_bytes = 0;    // bytes accepted by the block so far
	int          mismatches = 0;
	int          cycle_count = 0;
	logic        quiet_tail = 1'b0;
	logic        hold_done = 1'b0;
	logic        drain_done = 1'b0;
	u8u16_pkg::result_t seen_unit;
	u8u16_pkg::result_t want_unit;

	// One row of the directed part. Where typed is set, want is the expected
	// single result; otherwise the decoder model below supplies it.
	typedef struct packed {
		logic [7:0]         octet;
		logic               fin;
		logic               typed;
		u8u16_pkg::result_t want;
	} stim_row_t;

	localparam int DirectedCount = 25;
	localparam stim_row_t DirectedRows [DirectedCount] = '{
		// Straight after reset: NUL closing a one-byte string, then DEL.
		'{8'h00, 1'b1, 1'b1, '{16'h0000, 1'b0, u8u16_pkg::ERR_LEAD, 1'b1, 1'b1}},
		'{8'h7F, 1'b0, 1'b1, '{16'h007F, 1'b0, u8u16_pkg::ERR_LEAD, 1'b1, 1'b0}},
		// A stray continuation on the last byte: error but no dropping.
		'{8'h80, 1'b1, 1'b1, '{16'h0000, 1'b1, u8u16_pkg::ERR_LEAD, 1'b1, 1'b1}},
		// An impossible lead mid-string: error, then the next byte is dropped.
		'{8'hFF, 1'b0, 1'b1, '{16'h0000, 1'b1, u8u16_pkg::ERR_LEAD, 1'b1, 1'b1}},
		'{8'h41, 1'b1, 1'b0, '0},
		// Smallest two-byte point.
		'{8'hC2, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		// Overlong two-byte NUL.
		'{8'hC0, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b1, '{16'h0000, 1'b1, u8u16_pkg::ERR_OVERLONG, 1'b1, 1'b1}},
		// First high surrogate encoded directly.
		'{8'hED, 1'b0, 1'b0, '0},
		'{8'hA0, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b1, '{16'h0000, 1'b1, u8u16_pkg::ERR_SURROGATE, 1'b1, 1'b1}},
		// One past the top of the code space.
		'{8'hF4, 1'b0, 1'b0, '0},
		'{8'h90, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b1, '{16'h0000, 1'b1, u8u16_pkg::ERR_RANGE, 1'b1, 1'b1}},
		// Supplementary point, sent as a surrogate pair.
		'{8'hF0, 1'b0, 1'b0, '0},
		'{8'h9F, 1'b0, 1'b0, '0},
		'{8'h98, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b0, '0},
		// Bad middle byte, reported once the sequence is complete.
		'{8'hE2, 1'b0, 1'b0, '0},
		'{8'h41, 1'b0, 1'b0, '0},
		'{8'h82, 1'b1, 1'b1, '{16'h0000, 1'b1, u8u16_pkg::ERR_CONT, 1'b1, 1'b1}},
		// String cut off inside a three-byte sequence.
		'{8'hE2, 1'b0, 1'b0, '0},
		'{8'h82, 1'b1, 1'b1, '{16'h0000, 1'b1, u8u16_pkg::ERR_LEAD, 1'b1, 1'b1}}
	};

	// Works out the results of one accepted byte and advances the state.
	task automatic decode_octet(input logic [7:0] b, input logic fin,
			output u8u16_pkg::result_t r0, output u8u16_pkg::result_t r1, output int n);
		logic [2:0]  len;
		logic [20:0] least;
		logic [20:0] cp;
		logic [20:0] sup;
		logic        have_err;
		logic        have_point;
		u8u16_pkg::err_kind_t kind;
		n = 0;
		r0 = '0;
		r1 = '0;
		have_err = 1'b0;
		have_point = 1'b0;
		kind = u8u16_pkg::ERR_LEAD;
		cp = '0;
		if (skipping) begin
			// Everything up to and including the string's last byte is swallowed.
			if (fin) begin
				skipping = 1'b0;
				acc_point = '0;
				cont_left = '0;
				seq_len = '0;
				cont_broken = 1'b0;
			end
			return;
		end
		if (cont_left == 2'd0) begin
			casez (b)
				8'b0???????: len = 3'd1;
				8'b110?????: len = 3'd2;
				8'b1110????: len = 3'd3;
				8'b11110???: len = 3'd4;
				default:     len = 3'd0;
			endcase
			if (len == 3'd0 || (len != 3'd1 && fin)) begin
				have_err = 1'b1;
			end else if (len == 3'd1) begin
				have_point = 1'b1;
				cp = {14'd0, b[6:0]};
			end else begin
				case (len)
					3'd2:    acc_point = {16'd0, b[4:0]};
					3'd3:    acc_point = {17'd0, b[3:0]};
					default: acc_point = {18'd0, b[2:0]};
				endcase
				cont_left = len[1:0] - 2'd1;
				seq_len = len;
				cont_broken = 1'b0;
			end
		end else begin
			// A byte that is not 10xxxxxx still fills its slot in the sequence.
			if (b[7:6] != 2'b10)
				cont_broken = 1'b1;
			acc_point = {acc_point[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			least = (seq_len == 3'd2) ? u8u16_pkg::MinPoint2 :
				(seq_len == 3'd3) ? u8u16_pkg::MinPoint3 : u8u16_pkg::MinPoint4;
			if (cont_left != 2'd0) begin
				// Running out of string mid-sequence is a truncation, whatever else.
				have_err = fin;
			end else if (cont_broken) begin
				have_err = 1'b1;
				kind = u8u16_pkg::ERR_CONT;
			end else if (acc_point < least) begin
				have_err = 1'b1;
				kind = u8u16_pkg::ERR_OVERLONG;
			end else if (acc_point >= u8u16_pkg::SurrLo && acc_point <= u8u16_pkg::SurrHi) begin
				have_err = 1'b1;
				kind = u8u16_pkg::ERR_SURROGATE;
			end else if (acc_point > u8u16_pkg::MaxPoint) begin
				have_err = 1'b1;
				kind = u8u16_pkg::ERR_RANGE;
			end else begin
				have_point = 1'b1;
				cp = acc_point;
			end
		end
		if (have_err || have_point) begin
			acc_point = '0;
			cont_left = '0;
			seq_len = '0;
			cont_broken = 1'b0;
		end
		if (have_err) begin
			// An error on the last byte leaves the decoder ready for the next string.
			skipping = !fin;
			r0 = '{16'h0000, 1'b1, kind, 1'b1, 1'b1};
			n = 1;
		end else if (have_point) begin
			// The kind field is zero on code units.
			if (cp <= u8u16_pkg::BmpMax) begin
				r0 = '{cp[15:0], 1'b0, u8u16_pkg::ERR_LEAD, 1'b1, fin};
				n = 1;
			end else begin
				sup = cp - u8u16_pkg::SuppBase;
				r0 = '{{u8u16_pkg::HighPrefix, sup[19:10]}, 1'b0, u8u16_pkg::ERR_LEAD,
					1'b0, 1'b0};
				r1 = '{{u8u16_pkg::LowPrefix, sup[9:0]}, 1'b0, u8u16_pkg::ERR_LEAD,
					1'b1, fin};
				n = 2;
			end
		end
	endtask

	// Queues one expected result behind those already waiting.
	function automatic void expect_result(input u8u16_pkg::result_t r);
		pending_units.insert(pending_units.size(), r);
	endfunction

	// Offers one byte, waits for the transfer, then records what it should cause.
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
			input u8u16_pkg::result_t want);
		u8u16_pkg::result_t r0;
		u8u16_pkg::result_t r1;
		int      n;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		sent_bytes++;
		decode_octet(b, fin, r0, r1, n);
		if (typed) begin
			expect_result(want);
		end else begin
			if (n > 0)
				expect_result(r0);
			if (n > 1)
				expect_result(r1);
		end
	endtask

	// Random idle burst on the input side, except in the quiet tail of the run.
	task automatic input_gap();
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Now and then an end of the range, otherwise anything from lo to hi.
	function automatic int unsigned pick_in(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(0, 7))
			0:       return lo;
			1:       return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// A byte that cannot be a continuation byte.
	function automatic logic [7:0] stray_octet();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b[7:6] == 2'b10) begin
			if ($urandom_range(0, 1))
				b[7] = 1'b0;
			else
				b[6] = 1'b1;
		end
		return b;
	endfunction

	// Appends one byte to the string being built.
	function automatic void add_octet(input logic [7:0] b);
		octets.insert(octets.size(), b);
	endfunction

	// Encodes a point in n bytes; a short point in a long form gives an overlong.
	function automatic void append_seq(input logic [20:0] cp, input int n);
		case (n)
			1: add_octet({1'b0, cp[6:0]});
			2: begin
				add_octet({3'b110, cp[10:6]});
				add_octet({2'b10, cp[5:0]});
			end
			3: begin
				add_octet({4'b1110, cp[15:12]});
				add_octet({2'b10, cp[11:6]});
				add_octet({2'b10, cp[5:0]});
			end
			default: begin
				add_octet({5'b11110, cp[20:18]});
				add_octet({2'b10, cp[17:12]});
				add_octet({2'b10, cp[11:6]});
				add_octet({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// Fills octets with one string: mostly well-formed text with the odd fault,
	// sometimes plain noise.
	function automatic void build_string();
		int unsigned cat;
		int unsigned n;
		int unsigned keep;
		int unsigned start;
		int unsigned points;
		logic [20:0] cp;
		octets.delete();
		if ($urandom_range(0, 99) < 12) begin
			repeat ($urandom_range(1, 6)) add_octet(8'($urandom_range(0, 255)));
			return;
		end
		points = $urandom_range(1, 8);
		for (int i = 0; i < points; i++) begin
			cat = $urandom_range(0, 99);
			if (cat < 30) begin
				append_seq(21'(pick_in(0, 'h7F)), 1);
			end else if (cat < 48) begin
				append_seq(21'(pick_in('h80, 'h7FF)), 2);
			end else if (cat < 66) begin
				cp = 21'(pick_in('h800, 'hFFFF));
				if (cp >= u8u16_pkg::SurrLo && cp <= u8u16_pkg::SurrHi)
					cp ^= 21'h002000;
				append_seq(cp, 3);
			end else if (cat < 80) begin
				append_seq(21'(pick_in('h10000, 'h10FFFF)), 4);
			end else begin
				n = $urandom_range(2, 4);
				start = octets.size();
				case ($urandom_range(0, 6))
					0: append_seq(21'(pick_in(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF)),
						n);
					1: append_seq(21'(pick_in('hD800, 'hDFFF)), 3);
					2: append_seq(21'(pick_in('h110000, 'h1FFFFF)), 4);
					3: begin
						append_seq(21'($urandom_range(0, 'h1FFFFF)), n);
						octets[start + $urandom_range(1, n - 1)] = stray_octet();
					end
					4: add_octet(8'($urandom_range(0, 1) ?
						$urandom_range('h80, 'hBF) : $urandom_range('hF8, 'hFF)));
					5: begin
						// Cut the string short, now and then after a bad middle byte.
						append_seq(21'($urandom_range(0, 'h1FFFFF)), n);
						keep = $urandom_range(1, n - 1);
						repeat (n - keep) void'(octets.pop_back());
						if (keep >= 2 && $urandom_range(0, 1))
							octets[start + 1] = stray_octet();
						return;
					end
					default: add_octet(8'($urandom_range(0, 255)));
				endcase
			end
		end
	endfunction

	// Stimulus: reset, the directed table, then random strings.
	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		acc_point = '0;
		cont_left = '0;
		seq_len = '0;
		cont_broken = 1'b0;
		skipping = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DirectedRows[i]) begin
			input_gap();
			send_byte(DirectedRows[i].octet, DirectedRows[i].fin, DirectedRows[i].typed,
				DirectedRows[i].want);
		end
		while (sent_bytes < TargetBytes) begin
			build_string();
			foreach (octets[i]) begin
				if (!drain_done && sent_bytes >= DrainAt) begin
					// Let the block run dry before offering anything more.
					drain_done = 1'b1;
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending_units.size() != 0) @(posedge clk);
				end
				quiet_tail = (sent_bytes >= QuietFrom);
				input_gap();
				send_byte(octets[i], i == octets.size() - 1, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;
		while (pending_units.size() != 0) @(posedge clk);
		// Wait on so that any stray extra result is caught.
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_units.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Output side: short random stalls, and once a long hold-off so that the
	// block backs up and drops s_tready while bytes are still on offer.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && sent_bytes >= HoldAt) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_unit = '{m_tdata[15:0], m_tuser[0], u8u16_pkg::err_kind_t'(m_tuser[3:1]),
				m_tdata[16], m_tlast};
			if (pending_units.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: unit %h err %b kind %0d last %b close %b",
						seen_unit.code_unit, seen_unit.error_flag, seen_unit.error_kind,
						seen_unit.run_last, seen_unit.closes_string);
			end else begin
				want_unit = pending_units.pop_front();
				if (seen_unit.code_unit !== want_unit.code_unit ||
						seen_unit.error_flag !== want_unit.error_flag ||
						seen_unit.error_kind !== want_unit.error_kind ||
						seen_unit.run_last !== want_unit.run_last ||
						seen_unit.closes_string !== want_unit.closes_string) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected unit %h err %b kind %0d last %b close %b,",
							" got unit %h err %b kind %0d last %b close %b"},
							want_unit.code_unit, want_unit.error_flag, want_unit.error_kind,
							want_unit.run_last, want_unit.closes_string,
							seen_unit.code_unit, seen_unit.error_flag, seen_unit.error_kind,
							seen_unit.run_last, seen_unit.closes_string);
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

// ----- utf8_to_utf16_transcoder.f -----
rtl/u8u16_pkg.sv
rtl/utf8_to_utf16_transcoder.sv
test/utf8_to_utf16_transcoder_tb.sv
